// ----- design/ascchk_pkg.sv -----
// Package for the ASCII sentence checker: phase type, status codes,
// character constants and the byte-level helper functions.
// Depends on nothing; imported by ascii_sentence_checker.
package ascchk_pkg;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_BODY,
		PH_BODY_CR,
		PH_DIGITS,
		PH_TAIL,
		PH_TAIL_CR
	} phase_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_MISMATCH = 2'd1;
	localparam status_t ST_BAD_CHAR = 2'd2;
	localparam status_t ST_NO_STAR  = 2'd3;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	localparam logic [31:0] POLY_RESET = 32'hEDB88320;
	localparam logic [3:0]  XOR_DIGITS = 4'd2;
	localparam logic [3:0]  CRC_DIGITS = 4'd8;

	function automatic logic is_valid_char(input logic [7:0] b);
		return (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_CR) ||
			((b >= CH_SPACE) && (b <= CH_TILDE));
	endfunction

	// bit 4 set when the byte is a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			r = {1'b1, b[3:0]};
		end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	// reflected bytewise CRC update, no inversion
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
			input logic [31:0] poly);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			if (t[0]) begin
				t = (t >> 1) ^ poly;
			end else begin
				t = t >> 1;
			end
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

endpackage

// ----- design/ascii_sentence_checker.sv -----
// ASCII sentence checker top level: input byte register, framing phase
// logic with XOR / CRC-32 update, and result register.
// Depends on ascchk_pkg.
//
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid / in_ready        | data_byte
// result   | out_valid / out_ready      | sentence_kind, status, received_checksum,
//          |                            | computed_checksum
// config   | cfg_write_en (no wait)     | cfg_write_data (CRC polynomial)
//
// One byte per cycle while no held result stalls the input: a beat lands in the
// input register, is processed from there, and any result it causes is written
// into the result register.
// The byte-wide CRC update (eight shift steps) sets the cycle path.
// Reset returns the phase to hunting and the polynomial to 0xEDB88320.
// A held result stalls only a byte that would produce another result.
module ascii_sentence_checker
	import ascchk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sentence_kind,
	output logic [1:0]  status,
	output logic [31:0] received_checksum,
	output logic [31:0] computed_checksum,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] poly_q;
	phase_t      phase_q, phase_d;
	logic        kind_q, kind_d;
	logic [7:0]  xor_q, xor_d;
	logic [31:0] crc_q, crc_d;
	logic [3:0]  count_q, count_d;
	logic [31:0] parsed_q, parsed_d;

	logic        emit;
	status_t     emit_status;
	logic [31:0] emit_recv;
	logic [31:0] computed;
	logic [4:0]  hex;
	logic        char_ok;
	logic        advance;
	logic        out_valid_q;
	logic        kind_out_q;
	status_t     status_out_q;
	logic [31:0] recv_out_q;
	logic [31:0] comp_out_q;

	assign computed = kind_q ? crc_q : {24'd0, xor_q};
	assign hex      = hex_value(byte_s1);
	assign char_ok  = is_valid_char(byte_s1);

	always_comb begin
		phase_d     = phase_q;
		kind_d      = kind_q;
		xor_d       = xor_q;
		crc_d       = crc_q;
		count_d     = count_q;
		parsed_d    = parsed_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_recv   = parsed_q;
		case (phase_q)
			PH_HUNT: begin
				if ((byte_s1 == CH_DOLLAR) || (byte_s1 == CH_HASH)) begin
					kind_d   = (byte_s1 == CH_HASH);
					xor_d    = 8'd0;
					crc_d    = 32'd0;
					count_d  = 4'd0;
					parsed_d = 32'd0;
					phase_d  = PH_BODY;
				end
			end
			PH_BODY, PH_BODY_CR: begin
				if ((phase_q == PH_BODY_CR) && (byte_s1 == CH_LF)) begin
					emit        = 1'b1;
					emit_status = ST_NO_STAR;
					emit_recv   = 32'd0;
				end else if (!char_ok) begin
					emit        = 1'b1;
					emit_status = ST_BAD_CHAR;
					emit_recv   = 32'd0;
				end else if (byte_s1 == CH_STAR) begin
					count_d  = 4'd0;
					parsed_d = 32'd0;
					phase_d  = PH_DIGITS;
				end else begin
					xor_d   = xor_q ^ byte_s1;
					crc_d   = crc_byte(crc_q, byte_s1, poly_q);
					phase_d = (byte_s1 == CH_CR) ? PH_BODY_CR : PH_BODY;
				end
			end
			PH_DIGITS, PH_TAIL, PH_TAIL_CR: begin
				if ((phase_q == PH_DIGITS) && hex[4]) begin
					parsed_d = {parsed_q[27:0], hex[3:0]};
					count_d  = count_q + 4'd1;
					if (count_d >= (kind_q ? CRC_DIGITS : XOR_DIGITS)) begin
						phase_d = PH_TAIL;
					end
				end else if ((phase_q == PH_TAIL_CR) && (byte_s1 == CH_LF)) begin
					emit        = 1'b1;
					emit_status = (parsed_q == computed) ? ST_OK : ST_MISMATCH;
				end else if (byte_s1 == CH_CR) begin
					phase_d = PH_TAIL_CR;
				end else if (!char_ok) begin
					emit        = 1'b1;
					emit_status = ST_BAD_CHAR;
				end else begin
					phase_d = PH_TAIL;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (emit) begin
			phase_d = PH_HUNT;
		end
	end

	assign advance  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			poly_q      <= POLY_RESET;
			phase_q     <= PH_HUNT;
			kind_q      <= 1'b0;
			xor_q       <= 8'd0;
			crc_q       <= 32'd0;
			count_q     <= 4'd0;
			parsed_q    <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				poly_q <= cfg_write_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q  <= phase_d;
				kind_q   <= kind_d;
				xor_q    <= xor_d;
				crc_q    <= crc_d;
				count_q  <= count_d;
				parsed_q <= parsed_d;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
		if (advance && emit) begin
			kind_out_q   <= kind_q;
			status_out_q <= emit_status;
			recv_out_q   <= emit_recv;
			comp_out_q   <= computed;
		end
	end

	assign out_valid         = out_valid_q;
	assign sentence_kind     = kind_out_q;
	assign status            = status_out_q;
	assign received_checksum = recv_out_q;
	assign computed_checksum = comp_out_q;

	a_emit_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (phase_q == PH_HUNT))
		else $error("phase not back to hunting after a result");

	a_ok_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_out_q == ST_OK)) |-> (recv_out_q == comp_out_q))
		else $error("ok status with differing checksums");

	a_no_star_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_out_q == ST_NO_STAR)) |-> (recv_out_q == 32'd0))
		else $error("missing star result carries a received checksum");

	a_xor_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !kind_out_q) |-> (comp_out_q[31:8] == 24'd0))
		else $error("XOR result wider than a byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && emit && out_valid_q && !out_ready))
		else $error("input stalled without a held result");

endmodule
